@@ hw/rtl/three_level_ready_queue_with_aging_top_defines.svh @@
// Assertion macros used by the checker of the ready queue scheduler.
`ifndef THREE_LEVEL_READY_QUEUE_WITH_AGING_TOP_DEFINES_SVH
`define THREE_LEVEL_READY_QUEUE_WITH_AGING_TOP_DEFINES_SVH

`define TLRQ_ASSERT_ON(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

`define TLRQ_ASSERT(lbl, prop, msg) \
  `TLRQ_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`endif

@@ hw/rtl/tlrq_pkg.sv @@
package tlrq_pkg;

  localparam int PID_W      = 6;
  localparam int LVL_W      = 2;
  localparam int CNT8_W     = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;
  localparam logic [LVL_W-1:0] LVL_NONE = 2'd3;

  localparam logic MODE_READY = 1'b0;
  localparam logic MODE_SCHED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_AGING_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_PERIOD = 8'd1;

  localparam logic [CNT8_W-1:0] AGING_PERIOD_RST = 8'd10;

  typedef struct packed {
    logic             mode;
    logic [PID_W-1:0] ready_pid;
    logic [LVL_W-1:0] ready_level;
    logic             current_runnable;
    logic [LVL_W-1:0] current_level;
  } tlrq_in_t;

  typedef struct packed {
    logic [PID_W-1:0] next_pid;
    logic             none_ready;
    logic             overflow;
  } tlrq_out_t;

  typedef enum logic [1:0] {
    Q_NOP,
    Q_PUSH,
    Q_POP
  } qop_t;

  typedef struct packed {
    qop_t             op;
    logic [LVL_W-1:0] lvl;
  } qreq_t;

  typedef struct packed {
    logic [2:0] empty;
    logic [2:0] full;
  } qstat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENQ,
    S_AGE,
    S_MRD,
    S_MWR,
    S_LRD,
    S_LWR,
    S_REQ,
    S_SEL,
    S_SWR,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/tlrq_mem.sv @@
module tlrq_mem #(
  parameter int AW = 8,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/tlrq_qctl.sv @@
module tlrq_qctl #(
  parameter int MAX_PROCESSES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tlrq_pkg::qreq_t                    req,
  output tlrq_pkg::qstat_t                   stat,
  output logic                               mem_we,
  output logic [$clog2(MAX_PROCESSES)+1:0]   mem_waddr,
  output logic                               mem_re,
  output logic [$clog2(MAX_PROCESSES)+1:0]   mem_raddr
);

  import tlrq_pkg::*;

  localparam int IW = $clog2(MAX_PROCESSES);
  localparam int CW = $clog2(MAX_PROCESSES + 1);

  logic [IW-1:0] head_r [3];
  logic [IW-1:0] head_nxt [3];
  logic [IW-1:0] tail_r [3];
  logic [IW-1:0] tail_nxt [3];
  logic [CW-1:0] cnt_r [3];
  logic [CW-1:0] cnt_nxt [3];

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    for (int l = 0; l < 3; l++) begin
      head_nxt[l]   = head_r[l];
      tail_nxt[l]   = tail_r[l];
      cnt_nxt[l]    = cnt_r[l];
      stat.empty[l] = (cnt_r[l] == '0);
      stat.full[l]  = (cnt_r[l] == CW'(MAX_PROCESSES));
      if (req.lvl == LVL_W'(l)) begin
        if (req.op == Q_PUSH && !stat.full[l]) begin
          mem_we      = 1'b1;
          mem_waddr   = {req.lvl, tail_r[l]};
          tail_nxt[l] = (tail_r[l] == IW'(MAX_PROCESSES - 1)) ? '0 : tail_r[l] + 1'b1;
          cnt_nxt[l]  = cnt_r[l] + 1'b1;
        end else if (req.op == Q_POP && !stat.empty[l]) begin
          mem_re      = 1'b1;
          mem_raddr   = {req.lvl, head_r[l]};
          head_nxt[l] = (head_r[l] == IW'(MAX_PROCESSES - 1)) ? '0 : head_r[l] + 1'b1;
          cnt_nxt[l]  = cnt_r[l] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < 3; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < 3; l++) begin
        head_r[l] <= head_nxt[l];
        tail_r[l] <= tail_nxt[l];
        cnt_r[l]  <= cnt_nxt[l];
      end
    end
  end

endmodule

@@ hw/rtl/three_level_ready_queue_with_aging_top.sv @@
// Three-level ready queue scheduler with aging.
// An item is accepted when start is high and busy is low. Mode 0 appends
// ready_pid to ready_level; mode 1 reschedules: optional aging promotions,
// requeue of the running process, then dequeue of the highest nonempty level.
// Each item yields one result on out_data, marked by out_valid for one cycle.
// The receiver cannot stall; the result is simply presented for that cycle.
// All three levels share one queue memory with a write port and a read port,
// and a small sequencer performs at most one queue access per cycle. The
// length of a reschedule depends on aging promotions and on whether a process
// was found. busy falls in the cycle after out_valid.
// The configuration port is always ready; the user must write it only while
// the block idles, as the block itself does not enforce this.
// Synchronous reset empties all levels, sets the running id to zero, disables
// aging and loads both countdowns and the period with ten. The queue memory
// itself needs no clearing pass: an entry is read only after it was written.
module three_level_ready_queue_with_aging_top #(
  parameter int MAX_PROCESSES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tlrq_pkg::tlrq_in_t                  in_data,
  output logic                                out_valid,
  output tlrq_pkg::tlrq_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tlrq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlrq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import tlrq_pkg::*;

  localparam int AW = $clog2(MAX_PROCESSES) + 2;

  state_t            state_r, state_nxt;
  tlrq_in_t          in_r;
  logic [PID_W-1:0]  pid_r, pid_nxt;
  logic              none_r, ovf_r;
  logic              set_none, set_ovf;
  logic [CNT8_W-1:0] mcnt_r, mcnt_nxt, lcnt_r, lcnt_nxt;
  logic [CNT8_W-1:0] mdec, ldec;
  logic              age_en_r;
  logic [CNT8_W-1:0] period_r;
  logic              accept;

  qreq_t             qreq;
  qstat_t            qstat;
  logic [PID_W-1:0]  qwdata;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [PID_W-1:0]  mem_rdata;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign mdec      = mcnt_r - 1'b1;
  assign ldec      = lcnt_r - 1'b1;

  tlrq_qctl #(
    .MAX_PROCESSES(MAX_PROCESSES)
  ) u_qctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (qreq),
    .stat     (qstat),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr)
  );

  tlrq_mem #(
    .AW(AW),
    .DW(PID_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(qwdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.mode == MODE_SCHED) begin
            state_nxt = age_en_r ? S_AGE : S_REQ;
          end else begin
            state_nxt = S_ENQ;
          end
        end
      end
      S_ENQ:  state_nxt = S_DONE;
      S_AGE: begin
        state_nxt = (mdec == '0 && !qstat.empty[LVL_MED]) ? S_MRD : S_REQ;
      end
      S_MRD:  state_nxt = S_MWR;
      S_MWR: begin
        state_nxt = (ldec == '0 && !qstat.empty[LVL_LOW]) ? S_LRD : S_REQ;
      end
      S_LRD:  state_nxt = S_LWR;
      S_LWR:  state_nxt = S_REQ;
      S_REQ:  state_nxt = S_SEL;
      S_SEL:  state_nxt = (&qstat.empty) ? S_DONE : S_SWR;
      S_SWR:  state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    qreq.op  = Q_NOP;
    qreq.lvl = LVL_NONE;
    qwdata   = mem_rdata;
    set_ovf  = 1'b0;
    set_none = 1'b0;
    mcnt_nxt = mcnt_r;
    lcnt_nxt = lcnt_r;
    pid_nxt  = pid_r;
    out_valid = 1'b0;
    case (state_r)
      S_ENQ: begin
        qwdata = in_r.ready_pid;
        if (in_r.ready_level != LVL_NONE) begin
          qreq.op  = Q_PUSH;
          qreq.lvl = in_r.ready_level;
          set_ovf  = qstat.full[in_r.ready_level];
        end
      end
      S_AGE: begin
        mcnt_nxt = (mdec == '0) ? period_r : mdec;
      end
      S_MRD: begin
        qreq.op  = Q_POP;
        qreq.lvl = LVL_MED;
      end
      S_MWR: begin
        qreq.op  = Q_PUSH;
        qreq.lvl = LVL_HIGH;
        set_ovf  = qstat.full[LVL_HIGH];
        lcnt_nxt = (ldec == '0) ? period_r : ldec;
      end
      S_LRD: begin
        qreq.op  = Q_POP;
        qreq.lvl = LVL_LOW;
      end
      S_LWR: begin
        qreq.op  = Q_PUSH;
        qreq.lvl = LVL_MED;
        set_ovf  = qstat.full[LVL_MED];
      end
      S_REQ: begin
        qwdata = pid_r;
        if (in_r.current_runnable && in_r.current_level != LVL_NONE) begin
          qreq.op  = Q_PUSH;
          qreq.lvl = in_r.current_level;
          set_ovf  = qstat.full[in_r.current_level];
        end
      end
      S_SEL: begin
        qreq.op = Q_POP;
        if (!qstat.empty[LVL_HIGH]) begin
          qreq.lvl = LVL_HIGH;
        end else if (!qstat.empty[LVL_MED]) begin
          qreq.lvl = LVL_MED;
        end else if (!qstat.empty[LVL_LOW]) begin
          qreq.lvl = LVL_LOW;
        end else begin
          qreq.op  = Q_NOP;
          set_none = 1'b1;
        end
      end
      S_SWR: begin
        pid_nxt = mem_rdata;
      end
      S_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_data.next_pid   = pid_r;
  assign out_data.none_ready = none_r;
  assign out_data.overflow   = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pid_r    <= '0;
      none_r   <= 1'b0;
      ovf_r    <= 1'b0;
      mcnt_r   <= AGING_PERIOD_RST;
      lcnt_r   <= AGING_PERIOD_RST;
      age_en_r <= 1'b0;
      period_r <= AGING_PERIOD_RST;
    end else begin
      state_r <= state_nxt;
      pid_r   <= pid_nxt;
      mcnt_r  <= mcnt_nxt;
      lcnt_r  <= lcnt_nxt;
      if (accept) begin
        none_r <= 1'b0;
        ovf_r  <= 1'b0;
      end else begin
        if (set_none) begin
          none_r <= 1'b1;
        end
        if (set_ovf) begin
          ovf_r <= 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AGING_ENABLE: age_en_r <= cfg_wdata[0];
          CFG_AGING_PERIOD: period_r <= cfg_wdata;
          default: begin
            period_r <= period_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

endmodule

@@ hw/rtl/tlrq_checker.sv @@
`include "three_level_ready_queue_with_aging_top_defines.svh"

module tlrq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input tlrq_pkg::tlrq_out_t out_data
);

  `TLRQ_ASSERT(a_accept_busy, start && !busy |=> busy, "busy did not rise after an item")
  `TLRQ_ASSERT(a_result_busy, out_valid |-> busy, "result shown while idle")
  `TLRQ_ASSERT(a_result_once, out_valid |=> !out_valid && !busy, "result not a single strobe")
  `TLRQ_ASSERT(a_none_ovf, out_valid |-> !(out_data.none_ready && out_data.overflow), "overflow with all levels empty")

endmodule

bind three_level_ready_queue_with_aging_top tlrq_checker u_tlrq_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;
  import tlrq_pkg::*;

  localparam int QDEPTH      = 64;
  localparam int SETTLE      = 12;
  localparam int QUIET_LIMIT = 2000;
  localparam int SHOWN_MAX   = 10;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  tlrq_in_t              in_data   = '0;
  logic                  out_valid;
  tlrq_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    quiet_cycles = 0;

  three_level_ready_queue_with_aging_top #(
    .MAX_PROCESSES(QDEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  class sched_tracker;
    logic [PID_W-1:0]  levels[3][$];
    logic [PID_W-1:0]  running;
    logic [CNT8_W-1:0] med_count;
    logic [CNT8_W-1:0] low_count;
    logic              aging_on;
    logic [CNT8_W-1:0] period;
    tlrq_out_t         expected_picks[$];
    int                mismatches;

    function new();
      running    = '0;
      med_count  = AGING_PERIOD_RST;
      low_count  = AGING_PERIOD_RST;
      aging_on   = 1'b0;
      period     = AGING_PERIOD_RST;
      mismatches = 0;
    endfunction

    function int outstanding();
      return expected_picks.size();
    endfunction

    function bit enqueue(int lvl, logic [PID_W-1:0] pid);
      if (levels[lvl].size() >= QDEPTH) return 1'b1;
      levels[lvl].push_back(pid);
      return 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_AGING_ENABLE) aging_on = val[0];
      else if (idx == CFG_AGING_PERIOD) period = val;
    endfunction

    function void note_item(tlrq_in_t it);
      tlrq_out_t        res;
      logic [PID_W-1:0] moved;
      res = '0;
      if (it.mode == MODE_READY) begin
        if (it.ready_level != LVL_NONE) res.overflow = enqueue(it.ready_level, it.ready_pid);
      end else begin
        if (aging_on) begin
          med_count = med_count - 8'd1;
          if (med_count == '0) begin
            med_count = period;
            if (levels[LVL_MED].size() != 0) begin
              moved = levels[LVL_MED].pop_front();
              if (enqueue(LVL_HIGH, moved)) res.overflow = 1'b1;
              low_count = low_count - 8'd1;
              if (low_count == '0) begin
                low_count = period;
                if (levels[LVL_LOW].size() != 0) begin
                  moved = levels[LVL_LOW].pop_front();
                  if (enqueue(LVL_MED, moved)) res.overflow = 1'b1;
                end
              end
            end
          end
        end
        if (it.current_runnable && it.current_level != LVL_NONE) begin
          if (enqueue(it.current_level, running)) res.overflow = 1'b1;
        end
        if (levels[LVL_HIGH].size() != 0) running = levels[LVL_HIGH].pop_front();
        else if (levels[LVL_MED].size() != 0) running = levels[LVL_MED].pop_front();
        else if (levels[LVL_LOW].size() != 0) running = levels[LVL_LOW].pop_front();
        else res.none_ready = 1'b1;
      end
      res.next_pid = running;
      expected_picks.push_back(res);
    endfunction

    function void check_pick(tlrq_out_t got);
      tlrq_out_t want;
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("Result with no item pending: next_pid=%0d none_ready=%0b overflow=%0b",
                   got.next_pid, got.none_ready, got.overflow);
        return;
      end
      want = expected_picks.pop_front();
      if (got.next_pid !== want.next_pid || got.none_ready !== want.none_ready ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("Wrong result: expected pid=%0d none=%0b ovf=%0b, got pid=%0d none=%0b ovf=%0b",
                   want.next_pid, want.none_ready, want.overflow,
                   got.next_pid, got.none_ready, got.overflow);
      end
    endfunction
  endclass

  sched_tracker sb = new();

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_pick(out_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
      if (start && !busy) sb.note_item(in_data);
      if (out_valid || (cfg_valid && cfg_ready) || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout after %0d cycles without an item moving", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic tlrq_in_t pack_item(logic mode, logic [PID_W-1:0] pid,
                                         logic [LVL_W-1:0] rlvl, logic runnable,
                                         logic [LVL_W-1:0] clvl);
    tlrq_in_t it;
    it.mode             = mode;
    it.ready_pid        = pid;
    it.ready_level      = rlvl;
    it.current_runnable = runnable;
    it.current_level    = clvl;
    return it;
  endfunction

  function automatic logic [LVL_W-1:0] rand_level();
    if ($urandom_range(99) < 8) return LVL_NONE;
    return LVL_W'($urandom_range(2));
  endfunction

  function automatic tlrq_in_t rand_item(int ready_pct);
    logic mode;
    mode = ($urandom_range(99) < ready_pct) ? MODE_READY : MODE_SCHED;
    return pack_item(mode, PID_W'($urandom), rand_level(), 1'($urandom), rand_level());
  endfunction

  task automatic send_item(input tlrq_in_t it, input int idle_pct);
    in_data <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_aging(input logic enable, input logic [CFG_DATA_W-1:0] per);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_AGING_ENABLE;
    cfg_wdata <= {7'($urandom), enable};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_AGING_PERIOD;
    cfg_wdata <= per;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input int ready_pct, input int idle_pct);
    for (int i = 0; i < count; i++) send_item(rand_item(ready_pct), idle_pct);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(pack_item(MODE_SCHED, 6'd0, LVL_LOW, 1'b0, LVL_LOW), 0);
    send_item(pack_item(MODE_SCHED, 6'd0, LVL_LOW, 1'b1, LVL_HIGH), 0);
    send_item(pack_item(MODE_READY, 6'd63, LVL_LOW, 1'b0, LVL_LOW), 0);
    send_item(pack_item(MODE_READY, 6'd0, LVL_MED, 1'b1, LVL_NONE), 0);
    send_item(pack_item(MODE_READY, 6'd42, LVL_HIGH, 1'b0, LVL_LOW), 0);
    send_item(pack_item(MODE_READY, 6'd21, LVL_NONE, 1'b1, LVL_HIGH), 0);
    send_item(pack_item(MODE_SCHED, 6'd0, LVL_LOW, 1'b0, LVL_LOW), 0);
    send_item(pack_item(MODE_SCHED, 6'd63, LVL_NONE, 1'b1, LVL_LOW), 0);
    send_item(pack_item(MODE_SCHED, 6'd0, LVL_LOW, 1'b1, LVL_NONE), 0);
    send_item(pack_item(MODE_SCHED, 6'd0, LVL_LOW, 1'b1, LVL_MED), 0);
    send_item(pack_item(MODE_SCHED, 6'd0, LVL_LOW, 1'b0, LVL_LOW), 0);
    send_item(pack_item(MODE_SCHED, 6'd0, LVL_LOW, 1'b0, LVL_HIGH), 0);
    send_item(pack_item(MODE_READY, 6'd1, LVL_HIGH, 1'b1, LVL_NONE), 0);
    send_item(pack_item(MODE_SCHED, 6'd63, LVL_NONE, 1'b1, LVL_MED), 0);
    wait_drained();

    set_aging(1'b1, 8'd1);
    run_random(25, 55, 0);
    wait_drained();

    set_aging(1'b1, 8'd0);
    run_random(25, 55, 77);
    wait_drained();

    set_aging(1'b1, 8'd255);
    run_random(15, 55, 21);
    wait_drained();
    run_random(15, 55, 21);
    wait_drained();

    set_aging(1'b1, 8'd2);
    for (int i = 0; i < QDEPTH + 2; i++)
      send_item(pack_item(MODE_READY, PID_W'($urandom), LVL_HIGH, 1'($urandom),
                          rand_level()), 0);
    for (int i = 0; i < QDEPTH + 2; i++)
      send_item(pack_item(MODE_READY, PID_W'($urandom), LVL_MED, 1'($urandom),
                          rand_level()), 21);
    for (int i = 0; i < 10; i++)
      send_item(pack_item(MODE_READY, PID_W'($urandom), LVL_LOW, 1'($urandom),
                          rand_level()), 0);
    for (int i = 0; i < 20; i++)
      send_item(pack_item(MODE_SCHED, PID_W'($urandom), rand_level(), 1'b1,
                          LVL_W'($urandom_range(2))), 0);
    for (int i = 0; i < 150; i++)
      send_item(pack_item(MODE_SCHED, PID_W'($urandom), rand_level(), 1'b0,
                          rand_level()), 0);
    wait_drained();

    set_aging(1'b0, 8'd10);
    run_random(25, 50, 21);
    wait_drained();

    set_aging(1'b1, CFG_DATA_W'($urandom_range(3, 12)));
    run_random(20, 60, 77);
    run_random(20, 50, 0);
    wait_drained();

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
